@@ hw/rtl/gcd_pkg.sv @@
package gcd_pkg;

  localparam int GCD_OPERAND_BITS = 31;

  // microprogram counter
  localparam int PC_BITS = 3;
  typedef logic [PC_BITS-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_LOAD     = 3'd1,
    OP_SHR_BOTH = 3'd2,
    OP_SHR_A    = 3'd3,
    OP_SHR_B    = 3'd4,
    OP_SUB_SWAP = 3'd5,
    OP_SHL_A    = 3'd6,
    OP_EMIT     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS    = 3'd0,
    CND_ZERO_OPND = 3'd1,
    CND_BOTH_EVEN = 3'd2,
    CND_A_EVEN    = 3'd3,
    CND_B_EVEN    = 3'd4,
    CND_B_NONZERO = 3'd5,
    CND_K_NONZERO = 3'd6
  } cond_t;

  // op runs and pc takes tgt_true when cond holds, else pc takes tgt_false
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt_true;
    pc_t   tgt_false;
  } uword_t;

  typedef struct packed {
    logic zero_opnd;
    logic a_even;
    logic b_even;
    logic b_nonzero;
    logic k_nonzero;
  } dp_status_t;

  // program addresses
  localparam pc_t PC_CHECK  = 3'd0;
  localparam pc_t PC_TWOS   = 3'd1;
  localparam pc_t PC_ODD_A  = 3'd2;
  localparam pc_t PC_ODD_B  = 3'd3;
  localparam pc_t PC_SUB    = 3'd4;
  localparam pc_t PC_TEST   = 3'd5;
  localparam pc_t PC_RESTORE = 3'd6;
  localparam pc_t PC_EMIT   = 3'd7;

  // binary GCD microprogram
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_CHECK:   w = '{OP_NOP,      CND_ZERO_OPND, PC_EMIT,    PC_TWOS};
      PC_TWOS:    w = '{OP_SHR_BOTH, CND_BOTH_EVEN, PC_TWOS,    PC_ODD_A};
      PC_ODD_A:   w = '{OP_SHR_A,    CND_A_EVEN,    PC_ODD_A,   PC_ODD_B};
      PC_ODD_B:   w = '{OP_SHR_B,    CND_B_EVEN,    PC_ODD_B,   PC_SUB};
      PC_SUB:     w = '{OP_SUB_SWAP, CND_ALWAYS,    PC_TEST,    PC_TEST};
      PC_TEST:    w = '{OP_NOP,      CND_B_NONZERO, PC_ODD_B,   PC_RESTORE};
      PC_RESTORE: w = '{OP_SHL_A,    CND_K_NONZERO, PC_RESTORE, PC_EMIT};
      PC_EMIT:    w = '{OP_EMIT,     CND_ALWAYS,    PC_CHECK,   PC_CHECK};
      default:    w = '{OP_EMIT,     CND_ALWAYS,    PC_CHECK,   PC_CHECK};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/gcd_sequencer.sv @@
module gcd_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gcd_pkg::dp_status_t status,
  output gcd_pkg::op_t        op,
  output logic                busy,
  output logic                done
);

  gcd_pkg::pc_t   pc;
  gcd_pkg::pc_t   pc_next;
  gcd_pkg::uword_t uw;
  logic           cond_ok;
  logic           accept;

  assign accept = start && !busy;
  assign uw     = gcd_pkg::ucode(pc);

  always_comb begin
    unique case (uw.cond)
      gcd_pkg::CND_ALWAYS:    cond_ok = 1'b1;
      gcd_pkg::CND_ZERO_OPND: cond_ok = status.zero_opnd;
      gcd_pkg::CND_BOTH_EVEN: cond_ok = status.a_even && status.b_even;
      gcd_pkg::CND_A_EVEN:    cond_ok = status.a_even;
      gcd_pkg::CND_B_EVEN:    cond_ok = status.b_even;
      gcd_pkg::CND_B_NONZERO: cond_ok = status.b_nonzero;
      gcd_pkg::CND_K_NONZERO: cond_ok = status.k_nonzero;
      default:                cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = cond_ok ? uw.tgt_true : uw.tgt_false;
    priority if (accept) begin
      op = gcd_pkg::OP_LOAD;
    end else if (busy && cond_ok) begin
      op = uw.op;
    end else begin
      op = gcd_pkg::OP_NOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= gcd_pkg::PC_CHECK;
    end else begin
      done <= busy && (uw.op == gcd_pkg::OP_EMIT);
      if (accept) begin
        busy <= 1'b1;
        pc   <= gcd_pkg::PC_CHECK;
      end else if (busy) begin
        pc <= pc_next;
        if (uw.op == gcd_pkg::OP_EMIT) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hw/rtl/gcd_datapath.sv @@
module gcd_datapath #(
  parameter int OPERAND_BITS = gcd_pkg::GCD_OPERAND_BITS
) (
  input  logic                    clk,
  input  gcd_pkg::op_t            op,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  output gcd_pkg::dp_status_t     status,
  output logic [OPERAND_BITS-1:0] divisor,
  output logic                    zero_operand
);

  localparam int KW = $clog2(OPERAND_BITS + 1);

  logic [OPERAND_BITS-1:0] a;
  logic [OPERAND_BITS-1:0] b;
  logic [KW-1:0]           k;
  logic                    zero_opnd;
  logic [OPERAND_BITS:0]   diff_ba;
  logic [OPERAND_BITS-1:0] diff_ab;
  logic                    a_gt_b;

  // b - a with borrow out; borrow means a > b
  assign diff_ba = {1'b0, b} - {1'b0, a};
  assign a_gt_b  = diff_ba[OPERAND_BITS];
  assign diff_ab = a - b;

  assign status.zero_opnd = zero_opnd;
  assign status.a_even    = ~a[0];
  assign status.b_even    = ~b[0];
  assign status.b_nonzero = |b;
  assign status.k_nonzero = |k;

  always_ff @(posedge clk) begin
    unique case (op)
      gcd_pkg::OP_NOP: begin
      end
      gcd_pkg::OP_LOAD: begin
        a         <= operand_a;
        b         <= operand_b;
        k         <= '0;
        zero_opnd <= (operand_a == '0) || (operand_b == '0);
      end
      gcd_pkg::OP_SHR_BOTH: begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + KW'(1);
      end
      gcd_pkg::OP_SHR_A: a <= a >> 1;
      gcd_pkg::OP_SHR_B: b <= b >> 1;
      gcd_pkg::OP_SUB_SWAP: begin
        if (a_gt_b) begin
          a <= b;
          b <= diff_ab;
        end else begin
          b <= diff_ba[OPERAND_BITS-1:0];
        end
      end
      gcd_pkg::OP_SHL_A: begin
        a <= a << 1;
        k <= k - KW'(1);
      end
      gcd_pkg::OP_EMIT: begin
        divisor      <= zero_opnd ? '0 : a;
        zero_operand <= zero_opnd;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/gcd_unit.sv @@
// gcd_unit: greatest common divisor of two unsigned OPERAND_BITS-wide operands.
// Pulse start while busy is low to issue a request; operand_a/operand_b are
// sampled on that edge. The result appears on divisor/zero_operand for exactly
// one cycle, flagged by done; there is no backpressure, so the receiver must
// capture it in that cycle. divisor/zero_operand hold their value until the
// next result but are only meaningful while done is high. If either operand
// is zero, divisor is 0 and zero_operand is 1. busy drops in the cycle done is
// high, so a new request can be issued back-to-back with result delivery.
// Sequencing: one microinstruction per clock from a small ROM program (binary
// GCD). A zero operand branches straight from the check step to emit.
// Otherwise the run grows with the common factors of two, the single shifts
// of each operand and the subtracts, as the shift/subtract loop of the
// program sets it.
module gcd_unit #(
  parameter int OPERAND_BITS = gcd_pkg::GCD_OPERAND_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] divisor,
  output logic                    zero_operand
);

  gcd_pkg::op_t        op;      // datapath micro-op for this cycle
  gcd_pkg::dp_status_t status;  // branch flags back to the sequencer

  // Control: step counter + ROM lookup + branch select.
  gcd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy),
    .done   (done)
  );

  // Datapath: a/b working regs, shared-twos count k, subtract/compare.
  gcd_datapath #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk          (clk),
    .op           (op),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .status       (status),
    .divisor      (divisor),
    .zero_operand (zero_operand)
  );

`ifndef NO_ASSERTIONS
  // result strobe only ever follows a request in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done without a request in flight");

  // an accepted request keeps the unit busy the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("request accepted but unit not busy");

  // zero-operand results carry a zero divisor
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    done && zero_operand |-> divisor == '0)
    else $error("zero_operand set with nonzero divisor");

  // a real gcd is never zero
  a_nonzero_gcd: assert property (@(posedge clk) disable iff (rst)
    done && !zero_operand |-> divisor != '0)
    else $error("gcd of nonzero operands reported as zero");
`endif

endmodule

@@ verif/gcd_checker.sv @@
`timescale 1ns / 100ps

module gcd_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [gcd_pkg::GCD_OPERAND_BITS-1:0] operand_a,
  input  logic [gcd_pkg::GCD_OPERAND_BITS-1:0] operand_b,
  input  logic                                 done,
  input  logic [gcd_pkg::GCD_OPERAND_BITS-1:0] divisor,
  input  logic                                 zero_operand,
  output int                                   mismatches,
  output int                                   pending
);

  localparam int WIDTH = gcd_pkg::GCD_OPERAND_BITS;
  localparam int MAX_REPORTS = 10;

  typedef logic [WIDTH-1:0] operand_t;

  typedef struct packed {
    operand_t divisor;
    logic     zero_operand;
  } gcd_result_t;

  gcd_result_t expected_gcds[$];

  // Euclid's remainder loop; a zero operand gives divisor 0 with the flag set
  function automatic gcd_result_t predict_gcd(operand_t a, operand_t b);
    gcd_result_t res;
    operand_t    x;
    operand_t    y;
    operand_t    rem;
    if (a == '0 || b == '0) begin
      res.divisor = '0;
      res.zero_operand = 1'b1;
    end else begin
      x = a;
      y = b;
      while (y != '0) begin
        rem = x % y;
        x = y;
        y = rem;
      end
      res.divisor = x;
      res.zero_operand = 1'b0;
    end
    return res;
  endfunction

  // results are checked before the request on the same edge is queued:
  // busy drops while done is high, so both can happen together
  always @(posedge clk) begin
    gcd_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_gcds.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result divisor=%0d zero_operand=%0b",
                     $realtime, divisor, zero_operand);
        end else begin
          want = expected_gcds.pop_front();
          if (divisor !== want.divisor || zero_operand !== want.zero_operand) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch divisor exp=%0d act=%0d, zero_operand exp=%0b act=%0b",
                       $realtime, want.divisor, divisor, want.zero_operand, zero_operand);
          end
        end
      end
      if (start && !busy)
        expected_gcds.push_back(predict_gcd(operand_a, operand_b));
    end
    pending = expected_gcds.size();
  end

endmodule

@@ verif/gcd_unit_test.sv @@
`timescale 1ns / 100ps

module gcd_unit_test;

  localparam int WIDTH = gcd_pkg::GCD_OPERAND_BITS;
  localparam int RANDOM_REQUESTS = 1250;
  // no idling for this run of requests
  localparam int STEADY_FIRST = 450;
  localparam int STEADY_LAST = 749;
  // drain time after the last result, scaled by the operand width
  localparam int DRAIN_CYCLES = 8 * WIDTH;
  // longest idle gap plus the slowest request, with a wide margin
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [WIDTH-1:0] operand_t;

  localparam operand_t MAX_OPND = '1;
  localparam operand_t TOP_BIT = operand_t'(1) << (WIDTH - 1);

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  operand_t operand_a;
  operand_t operand_b;
  logic     done;
  operand_t divisor;
  logic     zero_operand;

  int mismatches;
  int pending;
  int quiet_cycles;

  gcd_unit uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .divisor      (divisor),
    .zero_operand (zero_operand)
  );

  // the checker sees the same pins and keeps the expected divisors itself
  gcd_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .divisor      (divisor),
    .zero_operand (zero_operand),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with neither an accepted request nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("gcd_unit test failed");
    $finish;
  end

  // One request. Inputs move on the falling edge; start stays high while
  // the block is busy, and the request is taken on the first rising edge
  // with busy low. A gap lowers start, waits for the block to go idle and
  // then holds start low for that many more cycles.
  task automatic issue_request(input operand_t a, input operand_t b, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      while (busy)
        @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
  endtask

  // idle gaps: short, medium, and more often long
  function automatic int pick_gap(input bit allow);
    int sel;
    sel = $urandom_range(0, 3);
    if (!allow || $urandom_range(0, 99) >= 18)
      return 0;
    case (sel)
      0: return $urandom_range(1, 3);
      1: return $urandom_range(4, 40);
      default: return $urandom_range(41, 250);
    endcase
  endfunction

  // random operand pairs, biased toward pairs with a real common divisor
  task automatic pick_operands(output operand_t a, output operand_t b);
    int unsigned mode;
    int unsigned factor;
    int unsigned shift;
    mode = $urandom_range(0, 99);
    if (mode < 40) begin
      // plain random, sometimes narrowed so both magnitudes show up
      a = operand_t'($urandom);
      b = operand_t'($urandom);
      if ($urandom_range(0, 1)) a = a >> $urandom_range(0, 29);
      if ($urandom_range(0, 1)) b = b >> $urandom_range(0, 29);
    end else if (mode < 65) begin
      // shared odd-or-even factor times two cofactors, fits in 31 bits
      factor = $urandom_range(1, 32767);
      a = operand_t'(factor * $urandom_range(1, 65535));
      b = operand_t'(factor * $urandom_range(1, 65535));
    end else if (mode < 80) begin
      // long runs of trailing zeros, shared and individual
      shift = $urandom_range(0, 30);
      a = operand_t'($urandom) << shift;
      b = operand_t'($urandom) << shift;
      a = a << $urandom_range(0, 3);
      b = b << $urandom_range(0, 3);
    end else if (mode < 88) begin
      a = operand_t'($urandom_range(0, 20));
      b = operand_t'($urandom_range(0, 20));
    end else if (mode < 94) begin
      a = operand_t'($urandom);
      b = a;
    end else begin
      // zero on one side or both
      a = operand_t'($urandom);
      b = operand_t'($urandom);
      case ($urandom_range(0, 2))
        0: a = '0;
        1: b = '0;
        default: begin
          a = '0;
          b = '0;
        end
      endcase
    end
  endtask

  initial begin
    operand_t a;
    operand_t b;
    start = 1'b0;
    operand_a = '0;
    operand_b = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero operands, extremes, equal operands, slow cases
    issue_request('0, '0, 0);
    issue_request('0, MAX_OPND, 0);
    issue_request(MAX_OPND, '0, 0);
    issue_request('0, operand_t'(1), 0);
    issue_request(operand_t'(1), operand_t'(1), 0);
    issue_request(operand_t'(1), MAX_OPND, 0);
    issue_request(MAX_OPND, operand_t'(1), 0);
    issue_request(MAX_OPND, MAX_OPND, 0);
    issue_request(MAX_OPND, MAX_OPND - operand_t'(1), 0);
    issue_request(TOP_BIT, TOP_BIT, 0);
    issue_request(TOP_BIT, TOP_BIT >> 1, 0);
    issue_request(TOP_BIT, MAX_OPND, 0);
    issue_request(operand_t'(2), TOP_BIT, 0);
    // consecutive Fibonacci numbers: longest Euclid chain in range
    issue_request(31'd1836311903, 31'd1134903170, 0);
    issue_request(31'd1134903170, 31'd1836311903, 0);
    issue_request(31'h2AAAAAAA, 31'h55555555, 0);
    issue_request(31'h55555554, 31'h2AAAAAAA, 0);
    issue_request(31'd12345, 31'd12345, 0);
    issue_request(31'd3 << 28, 31'd5 << 27, 0);
    issue_request(31'd2147483629, 31'd2147483587, 0);
    issue_request(31'd48, 31'd18, 0);
    issue_request(31'd18, 31'd48, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick_operands(a, b);
      issue_request(a, b, pick_gap(i < STEADY_FIRST || i > STEADY_LAST));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("gcd_unit test passed");
    else
      $display("gcd_unit test failed");
    $finish;
  end

endmodule
